/* src/gipea_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gipea_pkg
// Shared types and constants for the grouped interrupt pending/enable block.
// ----------------------------------------------------------------------------
package gipea_pkg;

   localparam int GROUP_BITS          = 32;
   localparam int IRQ_W               = 8;
   localparam int GRP_W               = 3;
   localparam int LINE_W              = 5;
   localparam int DEFAULT_GROUPS      = 8;
   localparam int DEFAULT_ROUTE_BASE  = 24;

   typedef enum logic [2:0] {
      KIND_LINE      = 3'd0,
      KIND_PEND_W1C  = 3'd1,
      KIND_EN_WRITE  = 3'd2,
      KIND_PEND_READ = 3'd3,
      KIND_EN_READ   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [GROUP_BITS-1:0] write_data;
      logic [GRP_W-1:0]      reg_group;
      logic                  line_level;
      logic [IRQ_W-1:0]      irq_number;
      kind_type              kind;
   } req_item_type;

   typedef struct packed {
      logic                  route_level;
      logic [LINE_W-1:0]     route_line;
      logic                  route_valid;
      logic [GROUP_BITS-1:0] read_data;
   } rsp_item_type;

endpackage
`default_nettype wire

/* src/gipea_state.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gipea_state
// Pending and enable words with the per-beat update and route decision.
// ----------------------------------------------------------------------------
module gipea_state
   import gipea_pkg::*;
#(
   parameter int GROUPS     = DEFAULT_GROUPS,
   parameter int ROUTE_BASE = DEFAULT_ROUTE_BASE
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   logic [GROUP_BITS-1:0] pending_ff [GROUPS];
   logic [GROUP_BITS-1:0] enable_ff  [GROUPS];

   logic [GRP_W-1:0]      grp;
   logic [GIDX_W-1:0]     gidx;
   logic                  in_range;
   logic [GROUP_BITS-1:0] pend;
   logic [GROUP_BITS-1:0] en;
   logic [GROUP_BITS-1:0] line_bit;
   logic [GROUP_BITS-1:0] pending_in;
   logic [GROUP_BITS-1:0] enable_in;
   logic                  pend_we;
   logic                  en_we;
   logic                  route_hit;
   logic                  route_lvl;
   logic [GROUP_BITS-1:0] rd_data;
   logic [LINE_W:0]       line_sum;

   assign grp      = (item.kind == KIND_LINE) ? item.irq_number[IRQ_W-1 -: GRP_W]
                                              : item.reg_group;
   assign in_range = ({1'b0, grp} < (GRP_W+1)'(GROUPS));
   assign gidx     = grp[GIDX_W-1:0];
   assign pend     = pending_ff[gidx];
   assign en       = enable_ff[gidx];
   assign line_bit = GROUP_BITS'(1) << item.irq_number[LINE_W-1:0];
   assign line_sum = (LINE_W+1)'(ROUTE_BASE) + (LINE_W+1)'(grp);

   always_comb begin
      pending_in = pend;
      enable_in  = en;
      pend_we    = 1'b0;
      en_we      = 1'b0;
      route_hit  = 1'b0;
      route_lvl  = 1'b0;
      rd_data    = '0;
      unique case (item.kind)
         KIND_LINE: begin
            pend_we = 1'b1;
            if (item.line_level) begin
               pending_in = pend | line_bit;
               route_hit  = |(line_bit & en);
               route_lvl  = 1'b1;
            end else begin
               pending_in = pend & ~line_bit;
               route_hit  = ~|(pending_in & en) && |(line_bit & en);
            end
         end
         KIND_PEND_W1C: begin
            pend_we    = 1'b1;
            pending_in = pend & ~item.write_data;
            route_hit  = ~|(pending_in & en) && |(item.write_data & en);
         end
         KIND_EN_WRITE: begin
            en_we     = 1'b1;
            enable_in = item.write_data;
            if (|(item.write_data & ~en & pend)) begin
               route_hit = ~|(pend & en);
               route_lvl = 1'b1;
            end else if (|(en & ~item.write_data & pend)) begin
               route_hit = ~|(pend & item.write_data);
            end
         end
         KIND_PEND_READ: rd_data = pend;
         KIND_EN_READ:   rd_data = en;
         default: ;
      endcase
   end

   always_comb begin
      result = '0;
      if (in_range) begin
         result.read_data = rd_data;
         if (route_hit) begin
            result.route_valid = 1'b1;
            result.route_line  = line_sum[LINE_W-1:0];
            result.route_level = route_lvl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GROUPS; g++) begin
            pending_ff[g] <= '0;
            enable_ff[g]  <= '0;
         end
      end else if (fire && in_range) begin
         if (pend_we) pending_ff[gidx] <= pending_in;
         if (en_we)   enable_ff[gidx]  <= enable_in;
      end
   end

endmodule
`default_nettype wire

/* src/grouped_irq_pending_enable_aggregator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_irq_pending_enable_aggregator
// Interrupt pending/enable words per group with route line updates.
// ----------------------------------------------------------------------------
// Path: a req beat passes the input register, then the result register.
// Throughput: one beat per cycle; the input register and the result register
// each hold one beat; both move when the result register is empty or drains.
// Reset: synchronous; clears all pending and enable words and both valids.
// ----------------------------------------------------------------------------
module grouped_irq_pending_enable_aggregator
   import gipea_pkg::*;
#(
   parameter int GROUPS     = DEFAULT_GROUPS,
   parameter int ROUTE_BASE = DEFAULT_ROUTE_BASE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] irq_number, [8] line_level, [11:9] reg_group, [43:12] write_data
   input  wire logic [47:0] req_tdata,
   // [2:0] kind
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] read_data, [32] route_valid, [37:33] route_line, [38] route_level
   output logic [39:0]      rsp_tdata
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   req_item_type in_item_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_item_in.kind       = kind_type'(req_tuser);
      in_item_in.irq_number = req_tdata[7:0];
      in_item_in.line_level = req_tdata[8];
      in_item_in.reg_group  = req_tdata[11:9];
      in_item_in.write_data = req_tdata[43:12];
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   gipea_state #(
      .GROUPS     (GROUPS),
      .ROUTE_BASE (ROUTE_BASE)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_item_ff <= in_item_in;
      if (advance) out_item_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_item_ff};

endmodule
`default_nettype wire
